@@ hw/rtl/spi_pkg.sv @@
// Shared widths, constants and word types for the segment pair intersection block.
package spi_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_BITS   = 16;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * COORD_BITS + 1;
  localparam int DET_W  = 2 * COORD_BITS + 1;
  localparam int NUM_W  = 2 * COORD_BITS + 2;
  localparam int DMAG_W = DET_W;
  localparam int NMAG_W = NUM_W + FRAC_BITS;
  localparam int CMP_W  = DMAG_W + COORD_BITS + 1;
  localparam int UNIT_W = 2 * COORD_BITS + 1;
  localparam int PNT_W  = 2 * COORD_BITS + 2;

  localparam logic [COORD_BITS-1:0] ONE_FX       = COORD_BITS'(1) << FRAC_BITS;
  localparam logic [COORD_BITS-1:0] MINUS_ONE_FX = COORD_BITS'(0) - ONE_FX;
  localparam logic [COORD_BITS-1:0] SAT_MAX      = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] SAT_MIN      = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [TOL_BITS-1:0]   TOL_RESET    = TOL_BITS'(1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_delta_x;
    logic signed [COORD_BITS-1:0] a_delta_y;
    logic signed [COORD_BITS-1:0] b_start_x;
    logic signed [COORD_BITS-1:0] b_start_y;
    logic signed [COORD_BITS-1:0] b_delta_x;
    logic signed [COORD_BITS-1:0] b_delta_y;
  } in_word_t;

  typedef struct packed {
    logic                         hit;
    logic signed [COORD_BITS-1:0] param_a;
    logic signed [COORD_BITS-1:0] param_b;
    logic signed [COORD_BITS-1:0] cross_x;
    logic signed [COORD_BITS-1:0] cross_y;
  } out_word_t;

  // data that rides along the divider
  typedef struct packed {
    logic                         det_ok;
    logic signed [COORD_BITS-1:0] a_start_x;
    logic signed [COORD_BITS-1:0] a_start_y;
    logic signed [COORD_BITS-1:0] a_delta_x;
    logic signed [COORD_BITS-1:0] a_delta_y;
  } side_t;

endpackage

@@ hw/rtl/spi_front.sv @@
// Front pipeline: differences, cross products, determinant test and divider operands.
module spi_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             v_i,
  input  spi_pkg::in_word_t                word_i,
  input  logic [spi_pkg::TOL_BITS-1:0]     tol,
  output logic                             v_o,
  output logic [spi_pkg::NMAG_W-1:0]       n_a_o,
  output logic [spi_pkg::NMAG_W-1:0]       n_b_o,
  output logic                             neg_a_o,
  output logic                             neg_b_o,
  output logic [spi_pkg::DMAG_W-1:0]       d_o,
  output spi_pkg::side_t                   side_o
);

  localparam int F  = spi_pkg::FRAC_BITS;
  localparam int DW = spi_pkg::DIFF_W;
  localparam int PW = spi_pkg::PROD_W;
  localparam int EW = spi_pkg::DET_W;
  localparam int NW = spi_pkg::NUM_W;

  // stage A
  logic                 a_v_r;
  spi_pkg::in_word_t    a_w_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r;
  // stage B
  logic                 b_v_r;
  spi_pkg::side_t       b_side_r;
  logic signed [PW-1:0] b_p0_r, b_p1_r, b_p2_r, b_p3_r, b_p4_r, b_p5_r;
  // stage C
  logic                 c_v_r;
  spi_pkg::side_t       c_side_r;
  logic signed [EW-1:0] c_det_r;
  logic signed [NW-1:0] c_na_r, c_nb_r;
  // stage D
  logic                 d_v_r;

  logic [EW-1:0] det_mag;
  logic [NW-1:0] na_mag, nb_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
    end else if (adv) begin
      a_v_r <= v_i;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
    end
  end

  assign det_mag = c_det_r[EW-1] ? EW'(-c_det_r) : EW'(c_det_r);
  assign na_mag  = c_na_r[NW-1] ? NW'(-c_na_r) : NW'(c_na_r);
  assign nb_mag  = c_nb_r[NW-1] ? NW'(-c_nb_r) : NW'(c_nb_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_w_r  <= word_i;
      a_dx_r <= DW'($signed(word_i.b_start_x)) - DW'($signed(word_i.a_start_x));
      a_dy_r <= DW'($signed(word_i.b_start_y)) - DW'($signed(word_i.a_start_y));

      b_side_r.det_ok    <= 1'b0;
      b_side_r.a_start_x <= a_w_r.a_start_x;
      b_side_r.a_start_y <= a_w_r.a_start_y;
      b_side_r.a_delta_x <= a_w_r.a_delta_x;
      b_side_r.a_delta_y <= a_w_r.a_delta_y;
      b_p0_r <= PW'($signed(a_w_r.b_delta_x)) * PW'($signed(a_w_r.a_delta_y));
      b_p1_r <= PW'($signed(a_w_r.b_delta_y)) * PW'($signed(a_w_r.a_delta_x));
      b_p2_r <= PW'($signed(a_w_r.b_delta_x)) * PW'(a_dy_r);
      b_p3_r <= PW'($signed(a_w_r.b_delta_y)) * PW'(a_dx_r);
      b_p4_r <= PW'($signed(a_w_r.a_delta_x)) * PW'(a_dy_r);
      b_p5_r <= PW'($signed(a_w_r.a_delta_y)) * PW'(a_dx_r);

      c_side_r <= b_side_r;
      c_det_r  <= EW'(b_p0_r) - EW'(b_p1_r);
      c_na_r   <= NW'(b_p2_r) - NW'(b_p3_r);
      c_nb_r   <= NW'(b_p4_r) - NW'(b_p5_r);

      side_o.det_ok    <= det_mag > (EW'(tol) << F);
      side_o.a_start_x <= c_side_r.a_start_x;
      side_o.a_start_y <= c_side_r.a_start_y;
      side_o.a_delta_x <= c_side_r.a_delta_x;
      side_o.a_delta_y <= c_side_r.a_delta_y;
      d_o           <= det_mag;
      n_a_o         <= {na_mag, {F{1'b0}}};
      n_b_o         <= {nb_mag, {F{1'b0}}};
      neg_a_o       <= c_na_r[NW-1] ^ c_det_r[EW-1];
      neg_b_o       <= c_nb_r[NW-1] ^ c_det_r[EW-1];
    end
  end

  assign v_o = d_v_r;

endmodule

@@ hw/rtl/spi_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, saturating signed result.
module spi_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  logic                               v_i,
  input  logic [spi_pkg::NMAG_W-1:0]         n_i,
  input  logic [spi_pkg::DMAG_W-1:0]         d_i,
  input  logic                               neg_i,
  input  spi_pkg::side_t                     side_i,
  output logic                               v_o,
  output logic [spi_pkg::COORD_BITS-1:0]     q_o,
  output spi_pkg::side_t                     side_o
);

  localparam int W  = spi_pkg::COORD_BITS;
  localparam int RW = spi_pkg::NMAG_W;
  localparam int DW = spi_pkg::DMAG_W;
  localparam int CW = spi_pkg::CMP_W;

  logic           st_v_r    [0:W];
  logic [RW-1:0]  st_rem_r  [0:W];
  logic [DW-1:0]  st_d_r    [0:W];
  logic [W-1:0]   st_q_r    [0:W];
  logic           st_neg_r  [0:W];
  logic           st_ovf_r  [0:W];
  spi_pkg::side_t st_side_r [0:W];
  logic           o_v_r;

  logic [W-1:0] q_mag;
  logic [W-1:0] q_neg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r[0] <= 1'b0;
    end else if (adv) begin
      st_v_r[0] <= v_i;
    end
  end

  // a quotient of 2^W or more saturates whatever its sign
  always_ff @(posedge clk) begin
    if (adv) begin
      st_rem_r[0]  <= n_i;
      st_d_r[0]    <= d_i;
      st_q_r[0]    <= '0;
      st_neg_r[0]  <= neg_i;
      st_ovf_r[0]  <= CW'(n_i) >= (CW'(d_i) << W);
      st_side_r[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= W; i++) begin : g_stage
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(st_d_r[i-1]) << (W - i);
    assign ge  = CW'(st_rem_r[i-1]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        st_v_r[i] <= 1'b0;
      end else if (adv) begin
        st_v_r[i] <= st_v_r[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rem_r[i]  <= ge ? (st_rem_r[i-1] - RW'(dsh)) : st_rem_r[i-1];
        st_d_r[i]    <= st_d_r[i-1];
        st_q_r[i]    <= {st_q_r[i-1][W-2:0], ge};
        st_neg_r[i]  <= st_neg_r[i-1];
        st_ovf_r[i]  <= st_ovf_r[i-1];
        st_side_r[i] <= st_side_r[i-1];
      end
    end
  end

  assign q_mag = st_q_r[W];
  assign q_neg = W'(0) - q_mag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (adv) begin
      o_v_r <= st_v_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_o <= st_side_r[W];
      if (st_neg_r[W]) begin
        q_o <= (st_ovf_r[W] || q_mag > spi_pkg::SAT_MIN) ? spi_pkg::SAT_MIN : q_neg;
      end else begin
        q_o <= (st_ovf_r[W] || q_mag[W-1]) ? spi_pkg::SAT_MAX : q_mag;
      end
    end
  end

  assign v_o = o_v_r;

endmodule

@@ hw/rtl/spi_back.sv @@
// Back pipeline: unit interval tests, intersection point and the output word register.
module spi_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           adv,
  input  logic                           v_i,
  input  logic [spi_pkg::COORD_BITS-1:0] ta_i,
  input  logic [spi_pkg::COORD_BITS-1:0] tb_i,
  input  spi_pkg::side_t                 side_i,
  input  logic [spi_pkg::TOL_BITS-1:0]   tol,
  output logic                           v_o,
  output spi_pkg::out_word_t             word_o
);

  localparam int W  = spi_pkg::COORD_BITS;
  localparam int F  = spi_pkg::FRAC_BITS;
  localparam int UW = spi_pkg::UNIT_W;
  localparam int PW = spi_pkg::PNT_W;
  localparam int SW = PW - F;

  logic                 e_v_r;
  logic [W-1:0]         e_ta_r, e_tb_r;
  spi_pkg::side_t       e_side_r;
  logic signed [UW-1:0] e_ua_r, e_ub_r;
  logic signed [PW-1:0] e_mx_r, e_my_r;
  logic                 f_v_r;

  logic signed [UW-1:0] thr;
  logic signed [PW-1:0] px, py;
  logic signed [SW-1:0] sx, sy;
  logic                 hit;
  logic [W-1:0]         cx, cy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= v_i;
      f_v_r <= e_v_r;
    end
  end

  // t * (1 - t), both scaled by 2^F
  always_ff @(posedge clk) begin
    if (adv) begin
      e_ta_r   <= ta_i;
      e_tb_r   <= tb_i;
      e_side_r <= side_i;
      e_ua_r   <= UW'($signed(ta_i)) * (UW'(spi_pkg::ONE_FX) - UW'($signed(ta_i)));
      e_ub_r   <= UW'($signed(tb_i)) * (UW'(spi_pkg::ONE_FX) - UW'($signed(tb_i)));
      e_mx_r   <= PW'($signed(ta_i)) * PW'($signed(side_i.a_delta_x));
      e_my_r   <= PW'($signed(ta_i)) * PW'($signed(side_i.a_delta_y));
    end
  end

  assign thr = UW'(0) - (UW'(tol) << F);
  assign px  = (PW'($signed(e_side_r.a_start_x)) <<< F) + e_mx_r;
  assign py  = (PW'($signed(e_side_r.a_start_y)) <<< F) + e_my_r;
  assign sx  = SW'(px >>> F);
  assign sy  = SW'(py >>> F);
  assign hit = e_side_r.det_ok && (e_ua_r >= thr) && (e_ub_r >= thr);

  always_comb begin
    if (sx > $signed(SW'($signed(spi_pkg::SAT_MAX)))) begin
      cx = spi_pkg::SAT_MAX;
    end else if (sx < $signed(SW'($signed(spi_pkg::SAT_MIN)))) begin
      cx = spi_pkg::SAT_MIN;
    end else begin
      cx = W'(sx);
    end
    if (sy > $signed(SW'($signed(spi_pkg::SAT_MAX)))) begin
      cy = spi_pkg::SAT_MAX;
    end else if (sy < $signed(SW'($signed(spi_pkg::SAT_MIN)))) begin
      cy = spi_pkg::SAT_MIN;
    end else begin
      cy = W'(sy);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_o.hit     <= hit;
      word_o.param_a <= e_side_r.det_ok ? e_ta_r : spi_pkg::MINUS_ONE_FX;
      word_o.param_b <= e_side_r.det_ok ? e_tb_r : spi_pkg::MINUS_ONE_FX;
      word_o.cross_x <= hit ? cx : spi_pkg::MINUS_ONE_FX;
      word_o.cross_y <= hit ? cy : spi_pkg::MINUS_ONE_FX;
    end
  end

  assign v_o = f_v_r;

endmodule

@@ hw/rtl/segment_pair_intersection.sv @@
// Segment pair intersection: top level, config register and pipeline control.
// Usage:
//   Input channel in_valid/in_stall/in_word carries one segment pair per word
//   (start and direction of A and B, signed Q16.16).
//   Output channel out_valid/out_stall/out_word returns one word per pair:
//   hit flag, position along A and B, intersection point.
//   cfg_wr_en/cfg_wr_data write the 16-bit tolerance (Q0.16); reset value 1.
// Depth: 40 register stages (4 front, 34 divider, 2 back). One word per cycle
//   sustained while the output is not stalled. The divider, which resolves one
//   quotient bit per stage, sets the depth.
// Reset: synchronous, active low; clears all stage valid bits, nothing in flight.
// Stall: while out_stall holds a waiting output word, the whole pipeline holds
//   and in_stall is raised; bubbles move forward whenever the output is free.
module segment_pair_intersection (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  spi_pkg::in_word_t            in_word,
  output logic                         out_valid,
  input  logic                         out_stall,
  output spi_pkg::out_word_t           out_word,
  input  logic                         cfg_wr_en,
  input  logic [spi_pkg::TOL_BITS-1:0] cfg_wr_data
);

  logic [spi_pkg::TOL_BITS-1:0] tol_r;
  logic                         adv;

  logic                         f_v;
  logic [spi_pkg::NMAG_W-1:0]   f_na, f_nb;
  logic                         f_nega, f_negb;
  logic [spi_pkg::DMAG_W-1:0]   f_d;
  spi_pkg::side_t               f_side;

  logic                           da_v, db_v;
  logic [spi_pkg::COORD_BITS-1:0] da_q, db_q;
  spi_pkg::side_t                 da_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= spi_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol_r <= cfg_wr_data;
    end
  end

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  spi_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .v_i     (in_valid),
    .word_i  (in_word),
    .tol     (tol_r),
    .v_o     (f_v),
    .n_a_o   (f_na),
    .n_b_o   (f_nb),
    .neg_a_o (f_nega),
    .neg_b_o (f_negb),
    .d_o     (f_d),
    .side_o  (f_side)
  );

  spi_div u_div_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (f_v),
    .n_i    (f_na),
    .d_i    (f_d),
    .neg_i  (f_nega),
    .side_i (f_side),
    .v_o    (da_v),
    .q_o    (da_q),
    .side_o (da_side)
  );

  spi_div u_div_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (f_v),
    .n_i    (f_nb),
    .d_i    (f_d),
    .neg_i  (f_negb),
    .side_i (f_side),
    .v_o    (db_v),
    .q_o    (db_q),
    .side_o ()
  );

  spi_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .v_i    (da_v & db_v),
    .ta_i   (da_q),
    .tb_i   (db_q),
    .side_i (da_side),
    .tol    (tol_r),
    .v_o    (out_valid),
    .word_o (out_word)
  );

endmodule

@@ bench/intersection_checker.sv @@
// Checker: watches both channels, predicts each result word and compares it.
module intersection_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  spi_pkg::in_word_t          in_word,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  spi_pkg::out_word_t         out_word,
  input  logic                       cfg_wr_en,
  input  logic [spi_pkg::TOL_BITS-1:0] cfg_wr_data,
  output int                         fail_count,
  output int                         pending
);

  logic [spi_pkg::TOL_BITS-1:0] tol_q;
  spi_pkg::out_word_t expected_q[$];
  int mismatch_count;

  function automatic logic signed [31:0] clamp32(logic signed [159:0] v);
    if (v > 160'sd2147483647) return spi_pkg::SAT_MAX;
    if (v < -160'sd2147483648) return spi_pkg::SAT_MIN;
    return v[31:0];
  endfunction

  function automatic logic unit_ok(logic signed [31:0] t, logic signed [159:0] thr);
    logic signed [159:0] p;
    p = 160'(t) * (160'sd65536 - 160'(t));
    return p >= -thr;
  endfunction

  function automatic spi_pkg::out_word_t predict_word(spi_pkg::in_word_t w,
                                                      logic [spi_pkg::TOL_BITS-1:0] tol);
    spi_pkg::out_word_t r;
    logic signed [159:0] det, absdet, thr, dx, dy, na, nb, ta, tb, px, py;
    r = '{hit: 1'b0, param_a: spi_pkg::MINUS_ONE_FX, param_b: spi_pkg::MINUS_ONE_FX,
          cross_x: spi_pkg::MINUS_ONE_FX, cross_y: spi_pkg::MINUS_ONE_FX};
    det = 160'(w.b_delta_x) * 160'(w.a_delta_y) - 160'(w.b_delta_y) * 160'(w.a_delta_x);
    absdet = det < 0 ? -det : det;
    thr = 160'($unsigned(tol)) <<< spi_pkg::FRAC_BITS;
    if (absdet > thr) begin
      dx = 160'(w.b_start_x) - 160'(w.a_start_x);
      dy = 160'(w.b_start_y) - 160'(w.a_start_y);
      na = 160'(w.b_delta_x) * dy - 160'(w.b_delta_y) * dx;
      nb = 160'(w.a_delta_x) * dy - 160'(w.a_delta_y) * dx;
      // signed division truncates toward zero
      ta = (na <<< spi_pkg::FRAC_BITS) / det;
      tb = (nb <<< spi_pkg::FRAC_BITS) / det;
      r.param_a = clamp32(ta);
      r.param_b = clamp32(tb);
      if (unit_ok(r.param_a, thr) && unit_ok(r.param_b, thr)) begin
        px = (160'(w.a_start_x) <<< spi_pkg::FRAC_BITS) +
             160'(r.param_a) * 160'(w.a_delta_x);
        py = (160'(w.a_start_y) <<< spi_pkg::FRAC_BITS) +
             160'(r.param_a) * 160'(w.a_delta_y);
        r.hit = 1'b1;
        r.cross_x = clamp32(px >>> spi_pkg::FRAC_BITS);
        r.cross_y = clamp32(py >>> spi_pkg::FRAC_BITS);
      end
    end
    return r;
  endfunction

  assign fail_count = mismatch_count;

  always @(posedge clk) begin
    spi_pkg::out_word_t e;
    if (!rst_n) begin
      tol_q <= spi_pkg::TOL_RESET;
      mismatch_count = 0;
      expected_q.delete();
      pending = 0;
    end else begin
      if (in_valid && !in_stall) expected_q.push_back(predict_word(in_word, tol_q));
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected word %h", out_word);
        end else begin
          e = expected_q.pop_front();
          if (e.hit !== out_word.hit || e.param_a !== out_word.param_a ||
              e.param_b !== out_word.param_b || e.cross_x !== out_word.cross_x ||
              e.cross_y !== out_word.cross_y) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"mismatch: exp hit=%0d ta=%h tb=%h x=%h y=%h ",
                        "got hit=%0d ta=%h tb=%h x=%h y=%h"},
                e.hit, e.param_a, e.param_b, e.cross_x, e.cross_y, out_word.hit,
                out_word.param_a, out_word.param_b, out_word.cross_x, out_word.cross_y);
          end
        end
      end
      if (cfg_wr_en) tol_q <= cfg_wr_data;
      pending = expected_q.size();
    end
  end
endmodule

@@ bench/testbench.sv @@
// Testbench top: stimulus, idling, configuration phases and the verdict.
module testbench;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  spi_pkg::in_word_t in_word = '0;
  spi_pkg::out_word_t out_word;
  logic cfg_wr_en = 1'b0;
  logic [spi_pkg::TOL_BITS-1:0] cfg_wr_data = '0;
  int fail_count, pending, cycle_count = 0;
  int send_idle_pct = 29, recv_idle_pct = 71;
  logic [spi_pkg::TOL_BITS-1:0] tols[4] = '{16'd0, 16'hffff, 16'd1, 16'd655};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_pair_intersection i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_wr_en, .cfg_wr_data
  );

  intersection_checker i_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_word, .out_valid, .out_stall, .out_word,
    .cfg_wr_en, .cfg_wr_data, .fail_count, .pending
  );

  always @(negedge clk) begin
    cycle_count++;
    out_stall <= ($urandom_range(99) < recv_idle_pct);
    if (cycle_count > 400000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
      3: return 32'($signed($urandom_range(0, 400 << 16)) - (200 << 16));
      4: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
    endcase
  endfunction

  function automatic spi_pkg::in_word_t rand_pair();
    spi_pkg::in_word_t w;
    w = {rand_coord(), rand_coord(), rand_coord(), rand_coord(),
         rand_coord(), rand_coord(), rand_coord(), rand_coord()};
    // sometimes make B nearly parallel to A
    if ($urandom_range(9) == 0) begin
      w.b_delta_x = w.a_delta_x;
      w.b_delta_y = w.a_delta_y + 32'($urandom_range(3));
    end
    return w;
  endfunction

  // in_valid stays high after the word goes; an idle cycle in the next send, or a drain, drops it
  task automatic send(spi_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [spi_pkg::TOL_BITS-1:0] v);
    drain();
    cfg_wr_data <= v;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    spi_pkg::in_word_t w;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // crossing diagonals, parallel, touching ends, extremes
    send('{0, 0, 32'h20000, 32'h20000, 0, 32'h20000, 32'h20000, 32'hfffe0000});
    send('{0, 0, 32'h10000, 0, 0, 32'h10000, 32'h10000, 0});
    send('{0, 0, 32'h10000, 0, 32'h10000, 0, 0, 32'h10000});
    send('{0, 0, 32'h10000, 0, 32'h30000, 32'hffff0000, 0, 32'h20000});
    send('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000});
    send('{32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
           32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
    send('{0, 0, 1, 0, 0, 0, 0, 1});
    send('{0, 0, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
           32'hffffffff, 32'h1});
    send('{0, 0, 32'h100, 32'h1, 32'h100, 0, 32'h1, 32'h100});
    send('0);
    send('1);
    for (int ph = 0; ph < 4; ph++) begin
      write_tolerance(tols[ph]);
      if (ph == 1) begin send_idle_pct = 71; recv_idle_pct = 29; end
      if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
      for (int k = 0; k < 385; k++) begin
        w = rand_pair();
        send(w);
        if (k == 200) drain();
      end
    end
    drain();
    if (fail_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

@@ sim.f @@
hw/rtl/spi_pkg.sv
hw/rtl/spi_front.sv
hw/rtl/spi_div.sv
hw/rtl/spi_back.sv
hw/rtl/segment_pair_intersection.sv
bench/intersection_checker.sv
bench/testbench.sv
